// ===== sv/mnpc_pkg.sv =====
// Shared types, constants and codes of the mesh node position commit unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package mnpc_pkg;

   // Node record store.
   localparam int NODE_COUNT = 4096;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int COUNT_BITS = 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Queue between the arithmetic front and the record back.
   localparam int QDEPTH   = 8;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int CREDIT_W = $clog2(QDEPTH + 1);

   localparam logic signed [23:0] BOX_RESET = 24'sd131072;

   // Item kinds.
   localparam logic [1:0] KIND_COMMIT      = 2'd0;
   localparam logic [1:0] KIND_REINIT      = 2'd1;
   localparam logic [1:0] KIND_CLEAR_TOTAL = 2'd2;

   // Register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 50;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_A_NORMAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_B_NORMAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_A_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_B_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_THRESH_SQ = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INACTIVE_LIMIT = 3'd5;

   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        node_index;
      logic signed [23:0] cur_x;
      logic signed [23:0] cur_y;
      logic signed [23:0] cur_z;
      logic signed [23:0] prop_x;
      logic signed [23:0] prop_y;
      logic signed [23:0] prop_z;
   } req_type;

   typedef struct packed {
      logic               at_interface;
      logic               is_moving;
      logic signed [23:0] out_x;
      logic signed [23:0] out_y;
      logic signed [23:0] out_z;
      logic [7:0]         idle_count;
      logic [31:0]        stopped_total;
      logic signed [23:0] box_min_x;
      logic signed [23:0] box_min_y;
      logic signed [23:0] box_min_z;
      logic signed [23:0] box_max_x;
      logic [47:0]        box_max_packed_yz;
   } rsp_type;

   typedef struct packed {
      logic [47:0]        plane_a_normal;
      logic [47:0]        plane_b_normal;
      logic signed [23:0] plane_a_offset;
      logic signed [23:0] plane_b_offset;
      logic [49:0]        move_threshold_squared;
      logic [7:0]         inactive_limit;
   } cfg_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        node_index;
      logic               iface;
      logic               short_move;
      logic signed [23:0] cur_x;
      logic signed [23:0] cur_y;
      logic signed [23:0] cur_z;
      logic signed [23:0] prop_x;
      logic signed [23:0] prop_y;
      logic signed [23:0] prop_z;
   } work_type;

   // Per-node activity record.
   typedef struct packed {
      logic                  moving;
      logic [COUNT_BITS-1:0] count;
   } rec_type;

   localparam rec_type REC_RESET = '{moving: 1'b1, count: '0};

endpackage
`default_nettype wire

// ===== sv/mnpc_front.sv =====
// Front end: accepts transactions, computes plane crossings and squared move length.
// Three pipeline stages feed the work queue; depends on mnpc_pkg.
`default_nettype none
module mnpc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mnpc_pkg::req_type  req_item,
   input  mnpc_pkg::cfg_type  cfg,
   input  logic               clr_busy,
   input  logic               q_pop,
   output logic               q_push,
   output mnpc_pkg::work_type q_item
);
   import mnpc_pkg::*;

   function automatic logic [42:0] mag43(input logic signed [42:0] a);
      return a[42] ? unsigned'(-a) : unsigned'(a);
   endfunction

   logic                accept;
   logic [CREDIT_W-1:0] credit_ff, credit_in;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   req_type             s1_item_ff, s2_item_ff, s3_item_ff;
   logic signed [24:0]  s1_v_ff [3];
   logic signed [24:0]  s1_v_in [3];
   logic signed [23:0]  req_p [3];
   logic signed [23:0]  req_q [3];
   logic signed [23:0]  s1_p [3];
   logic signed [15:0]  na [3];
   logic signed [15:0]  nb [3];

   logic signed [39:0]  s2_pap_ff [3], s2_pap_in [3];
   logic signed [39:0]  s2_pbp_ff [3], s2_pbp_in [3];
   logic signed [40:0]  s2_pav_ff [3], s2_pav_in [3];
   logic signed [40:0]  s2_pbv_ff [3], s2_pbv_in [3];
   logic [49:0]         s2_sq_ff [3], s2_sq_in [3];

   logic signed [42:0]  s3_da_ff, s3_da_in, s3_db_ff, s3_db_in;
   logic signed [42:0]  s3_va_ff, s3_va_in, s3_vb_ff, s3_vb_in;
   logic [50:0]         s3_d2_ff, s3_d2_in;

   logic                cross_a, cross_b, short_move;

   // Credits cover the pipeline and the queue, so the pipeline never stalls.
   assign req_ready = !clr_busy && (credit_ff < CREDIT_W'(QDEPTH));
   assign accept    = req_valid && req_ready;
   assign credit_in = credit_ff + CREDIT_W'(accept) - CREDIT_W'(q_pop);

   always_comb begin
      req_p[0] = req_item.cur_x;
      req_p[1] = req_item.cur_y;
      req_p[2] = req_item.cur_z;
      req_q[0] = req_item.prop_x;
      req_q[1] = req_item.prop_y;
      req_q[2] = req_item.prop_z;
      s1_p[0]  = s1_item_ff.cur_x;
      s1_p[1]  = s1_item_ff.cur_y;
      s1_p[2]  = s1_item_ff.cur_z;
      na[0]    = signed'(cfg.plane_a_normal[47:32]);
      na[1]    = signed'(cfg.plane_a_normal[31:16]);
      na[2]    = signed'(cfg.plane_a_normal[15:0]);
      nb[0]    = signed'(cfg.plane_b_normal[47:32]);
      nb[1]    = signed'(cfg.plane_b_normal[31:16]);
      nb[2]    = signed'(cfg.plane_b_normal[15:0]);
      for (int i = 0; i < 3; i++) begin
         s1_v_in[i]   = 25'(req_q[i]) - 25'(req_p[i]);
         s2_pap_in[i] = 40'(s1_p[i]) * 40'(na[i]);
         s2_pbp_in[i] = 40'(s1_p[i]) * 40'(nb[i]);
         s2_pav_in[i] = 41'(s1_v_ff[i]) * 41'(na[i]);
         s2_pbv_in[i] = 41'(s1_v_ff[i]) * 41'(nb[i]);
         s2_sq_in[i]  = unsigned'(50'(s1_v_ff[i]) * 50'(s1_v_ff[i]));
      end
   end

   // Plane terms carry 22 fraction bits, so the offset is moved up by 14.
   always_comb begin
      s3_da_in = 43'($signed({cfg.plane_a_offset, 14'd0})) - 43'(s2_pap_ff[0])
               - 43'(s2_pap_ff[1]) - 43'(s2_pap_ff[2]);
      s3_db_in = 43'($signed({cfg.plane_b_offset, 14'd0})) - 43'(s2_pbp_ff[0])
               - 43'(s2_pbp_ff[1]) - 43'(s2_pbp_ff[2]);
      s3_va_in = 43'(s2_pav_ff[0]) + 43'(s2_pav_ff[1]) + 43'(s2_pav_ff[2]);
      s3_vb_in = 43'(s2_pbv_ff[0]) + 43'(s2_pbv_ff[1]) + 43'(s2_pbv_ff[2]);
      s3_d2_in = 51'(s2_sq_ff[0]) + 51'(s2_sq_ff[1]) + 51'(s2_sq_ff[2]);
   end

   // A move parallel to a plane never crosses it.
   assign cross_a    = (s3_va_ff != '0) && (mag43(s3_da_ff) < mag43(s3_va_ff));
   assign cross_b    = (s3_vb_ff != '0) && (mag43(s3_db_ff) < mag43(s3_vb_ff));
   assign short_move = s3_d2_ff < 51'(cfg.move_threshold_squared);

   always_comb begin
      q_push            = s3_valid_ff;
      q_item.kind       = s3_item_ff.kind;
      q_item.node_index = s3_item_ff.node_index;
      q_item.iface      = cross_a || cross_b;
      q_item.short_move = short_move;
      q_item.cur_x      = s3_item_ff.cur_x;
      q_item.cur_y      = s3_item_ff.cur_y;
      q_item.cur_z      = s3_item_ff.cur_z;
      q_item.prop_x     = s3_item_ff.prop_x;
      q_item.prop_y     = s3_item_ff.prop_y;
      q_item.prop_z     = s3_item_ff.prop_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= req_item;
      s2_item_ff <= s1_item_ff;
      s3_item_ff <= s2_item_ff;
      for (int i = 0; i < 3; i++) begin
         s1_v_ff[i]   <= s1_v_in[i];
         s2_pap_ff[i] <= s2_pap_in[i];
         s2_pbp_ff[i] <= s2_pbp_in[i];
         s2_pav_ff[i] <= s2_pav_in[i];
         s2_pbv_ff[i] <= s2_pbv_in[i];
         s2_sq_ff[i]  <= s2_sq_in[i];
      end
      s3_da_ff <= s3_da_in;
      s3_db_ff <= s3_db_in;
      s3_va_ff <= s3_va_in;
      s3_vb_ff <= s3_vb_in;
      s3_d2_ff <= s3_d2_in;
   end

endmodule
`default_nettype wire

// ===== sv/mnpc_queue.sv =====
// Work queue between the front end and the record back end.
// A small circular buffer of classified items; depends on mnpc_pkg.
`default_nettype none
module mnpc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mnpc_pkg::work_type push_item,
   input  logic               pop,
   output mnpc_pkg::work_type head_item,
   output logic               empty,
   output logic               full
);
   import mnpc_pkg::*;

   work_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_W-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CREDIT_W'(QDEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CREDIT_W'(do_push) - CREDIT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/mnpc_back.sv =====
// Back end: per-node record read-modify-write, stop total, bounding box, result register.
// Holds the node record memory and its clearing pass; depends on mnpc_pkg.
`default_nettype none
module mnpc_back (
   input  logic               clock,
   input  logic               reset,
   input  mnpc_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  mnpc_pkg::work_type q_item,
   output logic               q_pop,
   output logic               clr_busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mnpc_pkg::rsp_type  rsp_item
);
   import mnpc_pkg::*;

   rec_type              mem [NODE_COUNT];
   rec_type              mem_q_ff;
   logic                 mem_we;
   logic [NODE_AW-1:0]   mem_waddr;
   rec_type              mem_wdata;
   logic [NODE_AW-1:0]   rd_addr;

   logic                 clr_busy_ff;
   logic [NODE_AW-1:0]   clr_addr_ff;

   logic                 b1_valid_ff;
   work_type             b1_item_ff;
   logic                 fwd_hit_ff, fwd_hit_in;
   rec_type              fwd_rec_ff;
   logic                 b1_fire;
   logic [NODE_AW-1:0]   b1_addr;

   logic                 rsp_valid_ff;
   rsp_type              rsp_item_ff, rsp_item_in;

   logic [31:0]          total_ff, total_in;
   logic signed [23:0]   box_lo_ff [3], box_lo_in [3];
   logic signed [23:0]   box_hi_ff [3], box_hi_in [3];
   logic signed [23:0]   p [3];
   logic signed [23:0]   q [3];
   logic signed [23:0]   res [3];

   logic                 idx_ok, commit_path, wr_needed, stop, take_q;
   rec_type              cur_rec, new_rec;
   logic [COUNT_BITS-1:0] cnt_inc;

   assign clr_busy  = clr_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign b1_fire = b1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign q_pop   = !q_empty && !clr_busy_ff && (!b1_valid_ff || b1_fire);
   assign b1_addr = NODE_AW'(b1_item_ff.node_index);
   assign rd_addr = NODE_AW'(q_item.node_index);

   // A read issued on the edge where the item ahead writes the same node sees
   // the old entry, so the written record is kept aside for it.
   assign cur_rec = fwd_hit_ff ? fwd_rec_ff : mem_q_ff;

   always_comb begin
      p[0] = b1_item_ff.cur_x;
      p[1] = b1_item_ff.cur_y;
      p[2] = b1_item_ff.cur_z;
      q[0] = b1_item_ff.prop_x;
      q[1] = b1_item_ff.prop_y;
      q[2] = b1_item_ff.prop_z;

      idx_ok      = 32'(b1_item_ff.node_index) < NODE_COUNT;
      commit_path = idx_ok && (b1_item_ff.kind == KIND_COMMIT) && !b1_item_ff.iface;
      cnt_inc     = (cur_rec.count != COUNT_MAX) ? cur_rec.count + 1'b1 : cur_rec.count;
      stop        = 32'(cnt_inc) > 32'(cfg.inactive_limit);

      new_rec = cur_rec;
      if (idx_ok && (b1_item_ff.kind == KIND_REINIT)) begin
         new_rec = REC_RESET;
      end else if (commit_path) begin
         if (b1_item_ff.short_move) begin
            new_rec.count  = cnt_inc;
            new_rec.moving = stop ? 1'b0 : cur_rec.moving;
         end else begin
            new_rec = REC_RESET;
         end
      end
      wr_needed = idx_ok && ((b1_item_ff.kind == KIND_REINIT) || commit_path);

      total_in = total_ff;
      if (b1_item_ff.kind == KIND_CLEAR_TOTAL) begin
         total_in = '0;
      end else if (commit_path && b1_item_ff.short_move && stop && (total_ff != '1)) begin
         total_in = total_ff + 1'b1;
      end

      take_q = commit_path && new_rec.moving;
      for (int i = 0; i < 3; i++) begin
         res[i]       = take_q ? q[i] : p[i];
         box_lo_in[i] = (take_q && (q[i] < box_lo_ff[i])) ? q[i] : box_lo_ff[i];
         box_hi_in[i] = (take_q && (q[i] > box_hi_ff[i])) ? q[i] : box_hi_ff[i];
      end

      rsp_item_in.at_interface = idx_ok && (b1_item_ff.kind == KIND_COMMIT)
                               && b1_item_ff.iface;
      rsp_item_in.is_moving    = idx_ok && new_rec.moving;
      rsp_item_in.out_x        = res[0];
      rsp_item_in.out_y        = res[1];
      rsp_item_in.out_z        = res[2];
      if (!idx_ok) begin
         rsp_item_in.idle_count = '0;
      end else if (32'(new_rec.count) > 32'd255) begin
         rsp_item_in.idle_count = 8'hFF;
      end else begin
         rsp_item_in.idle_count = 8'(new_rec.count);
      end
      rsp_item_in.stopped_total     = total_in;
      rsp_item_in.box_min_x         = box_lo_in[0];
      rsp_item_in.box_min_y         = box_lo_in[1];
      rsp_item_in.box_min_z         = box_lo_in[2];
      rsp_item_in.box_max_x         = box_hi_in[0];
      rsp_item_in.box_max_packed_yz = {box_hi_in[1], box_hi_in[2]};
   end

   // The clearing pass owns the write port; no transaction runs meanwhile.
   always_comb begin
      mem_we     = clr_busy_ff || (b1_fire && wr_needed);
      mem_waddr  = clr_busy_ff ? clr_addr_ff : b1_addr;
      mem_wdata  = clr_busy_ff ? REC_RESET : new_rec;
      fwd_hit_in = b1_fire && wr_needed && (b1_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (q_pop) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            box_lo_ff[i] <= '0;
            box_hi_ff[i] <= BOX_RESET;
         end
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == NODE_AW'(NODE_COUNT - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (q_pop) begin
            b1_valid_ff <= 1'b1;
         end else if (b1_fire) begin
            b1_valid_ff <= 1'b0;
         end
         if (b1_fire) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= total_in;
            for (int i = 0; i < 3; i++) begin
               box_lo_ff[i] <= box_lo_in[i];
               box_hi_ff[i] <= box_hi_in[i];
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_item_ff <= q_item;
         fwd_hit_ff <= fwd_hit_in;
         fwd_rec_ff <= new_rec;
      end
      if (b1_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/mesh_node_position_commit_unit.sv =====
// Top level of the mesh node position commit unit: register file, front end, work
// queue and record back end. Depends on mnpc_pkg, mnpc_front, mnpc_queue, mnpc_back.
//
// Usage:
//  - req_* carries one node per transaction: kind, node index, current and proposed
//    position. rsp_* returns exactly one result per request, in order.
//  - csr_* writes the plane normals, offsets, squared move threshold and inactivity
//    limit; csr_ready is always high. Write only while no request is in flight.
//  - One request is taken per cycle when the receiver keeps up; the node record
//    read-modify-write forwards the written record to a back-to-back request for
//    the same node.
//  - The front end runs a three-stage multiply/add pipeline and never stalls; an
//    eight-entry queue and credits keep it from overrunning the back end.
//  - After reset the node record memory is cleared, one entry per cycle, through
//    all 4096 entries; req_ready stays low meanwhile. Config registers take reset values.
//  - When the receiver stalls, the result register holds, the back end stops, and
//    req_ready drops once eight requests are queued or in the front pipeline.
`default_nettype none
module mesh_node_position_commit_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mnpc_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mnpc_pkg::rsp_type                   rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mnpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mnpc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mnpc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     clr_busy;
   logic     q_push, q_pop, q_empty, q_full;
   work_type q_push_item, q_head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PLANE_A_NORMAL: cfg_in.plane_a_normal = csr_data[47:0];
            CSR_PLANE_B_NORMAL: cfg_in.plane_b_normal = csr_data[47:0];
            CSR_PLANE_A_OFFSET: cfg_in.plane_a_offset = signed'(csr_data[23:0]);
            CSR_PLANE_B_OFFSET: cfg_in.plane_b_offset = signed'(csr_data[23:0]);
            CSR_MOVE_THRESH_SQ: cfg_in.move_threshold_squared = csr_data[49:0];
            CSR_INACTIVE_LIMIT: cfg_in.inactive_limit = csr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_a_normal         <= 48'd16384;
         cfg_ff.plane_b_normal         <= 48'd49152;
         cfg_ff.plane_a_offset         <= 24'sd256;
         cfg_ff.plane_b_offset         <= 24'sd256;
         cfg_ff.move_threshold_squared <= 50'd65536;
         cfg_ff.inactive_limit         <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mnpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .clr_busy  (clr_busy),
      .q_pop     (q_pop),
      .q_push    (q_push),
      .q_item    (q_push_item)
   );

   mnpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   mnpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_item    (q_head_item),
      .q_pop     (q_pop),
      .clr_busy  (clr_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Credits must keep the queue from ever being pushed while full.
   a_queue_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("work queue pushed while full");

   a_queue_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("work queue popped while empty");

   a_clear_quiet : assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> (!rsp_valid && !q_push && !req_ready))
      else $error("activity during record clearing pass");

   a_accept_reaches_queue : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##3 q_push)
      else $error("accepted transaction did not reach the work queue");

endmodule
`default_nettype wire

// ===== tb/sv/mnpc_commit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the mesh node position commit unit: tracks register writes, predicts each
// result from its own copy of the node records and compares it. Depends on mnpc_pkg.
module mnpc_commit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  mnpc_pkg::req_type               req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  mnpc_pkg::rsp_type               rsp_item,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mnpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mnpc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              mismatches,
   output int                              awaiting
);
   import mnpc_pkg::*;

   cfg_type               regs;
   logic [COUNT_BITS-1:0] node_count [NODE_COUNT];
   logic                  node_moving [NODE_COUNT];
   logic [31:0]           stop_total;
   logic signed [23:0]    box_lo [3];
   logic signed [23:0]    box_hi [3];
   rsp_type               due_results [$];

   // Crossing test without the division: the distance of the start point from the
   // plane, scaled to the dot product's 22 fraction bits, against the move's projection.
   function automatic bit plane_crossed(input logic [47:0] nrm, input logic signed [23:0] off,
                                        input longint px, py, pz, vx, vy, vz);
      longint nx, ny, nz, pn, vn, gap;
      nx = longint'($signed(nrm[47:32]));
      ny = longint'($signed(nrm[31:16]));
      nz = longint'($signed(nrm[15:0]));
      pn = px * nx + py * ny + pz * nz;
      vn = vx * nx + vy * ny + vz * nz;
      if (vn == 0) return 1'b0;
      gap = longint'(off) * 16384 - pn;
      if (gap < 0) gap = -gap;
      if (vn < 0) vn = -vn;
      return gap < vn;
   endfunction

   function automatic rsp_type commit_node(input req_type r);
      rsp_type            o;
      logic signed [23:0] src [3];
      logic signed [23:0] tgt [3];
      logic signed [23:0] pos [3];
      longint             v [3];
      longint             d2;
      bit                 iface;
      int                 n;
      n = int'(r.node_index);
      src[0] = r.cur_x;  src[1] = r.cur_y;  src[2] = r.cur_z;
      tgt[0] = r.prop_x; tgt[1] = r.prop_y; tgt[2] = r.prop_z;
      for (int i = 0; i < 3; i++) begin
         v[i] = longint'(tgt[i]) - longint'(src[i]);
         pos[i] = src[i];
      end
      iface = 1'b0;
      if (r.kind == KIND_CLEAR_TOTAL) stop_total = '0;
      if (r.kind == KIND_REINIT) begin
         node_count[n] = '0;
         node_moving[n] = 1'b1;
      end else if (r.kind == KIND_COMMIT) begin
         iface = plane_crossed(regs.plane_a_normal, regs.plane_a_offset,
                               src[0], src[1], src[2], v[0], v[1], v[2]) ||
                 plane_crossed(regs.plane_b_normal, regs.plane_b_offset,
                               src[0], src[1], src[2], v[0], v[1], v[2]);
         if (!iface) begin
            d2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
            if (d2 < longint'(regs.move_threshold_squared)) begin
               if (node_count[n] != COUNT_MAX) node_count[n]++;
               if (node_count[n] > regs.inactive_limit) begin
                  node_moving[n] = 1'b0;
                  if (stop_total != '1) stop_total++;
               end
            end else begin
               node_count[n] = '0;
               node_moving[n] = 1'b1;
            end
            if (node_moving[n]) begin
               for (int i = 0; i < 3; i++) begin
                  pos[i] = tgt[i];
                  if (tgt[i] < box_lo[i]) box_lo[i] = tgt[i];
                  if (tgt[i] > box_hi[i]) box_hi[i] = tgt[i];
               end
            end
         end
      end
      o.at_interface      = iface;
      o.is_moving         = node_moving[n];
      o.out_x             = pos[0];
      o.out_y             = pos[1];
      o.out_z             = pos[2];
      o.idle_count        = node_count[n];
      o.stopped_total     = stop_total;
      o.box_min_x         = box_lo[0];
      o.box_min_y         = box_lo[1];
      o.box_min_z         = box_lo[2];
      o.box_max_x         = box_hi[0];
      o.box_max_packed_yz = {box_hi[1], box_hi[2]};
      return o;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         regs.plane_a_normal         = 48'd16384;
         regs.plane_b_normal         = 48'd49152;
         regs.plane_a_offset         = 24'sd256;
         regs.plane_b_offset         = 24'sd256;
         regs.move_threshold_squared = 50'd65536;
         regs.inactive_limit         = 8'd1;
         for (int i = 0; i < NODE_COUNT; i++) begin
            node_count[i] = '0;
            node_moving[i] = 1'b1;
         end
         stop_total = '0;
         for (int i = 0; i < 3; i++) begin
            box_lo[i] = '0;
            box_hi[i] = BOX_RESET;
         end
         due_results.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PLANE_A_NORMAL: regs.plane_a_normal = csr_data[47:0];
               CSR_PLANE_B_NORMAL: regs.plane_b_normal = csr_data[47:0];
               CSR_PLANE_A_OFFSET: regs.plane_a_offset = csr_data[23:0];
               CSR_PLANE_B_OFFSET: regs.plane_b_offset = csr_data[23:0];
               CSR_MOVE_THRESH_SQ: regs.move_threshold_squared = csr_data[49:0];
               CSR_INACTIVE_LIMIT: regs.inactive_limit = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) due_results.push_back(commit_node(req_item));
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: result with no request outstanding, actual %h", $time, rsp_item);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("at_interface", 64'(want.at_interface),
                           64'(rsp_item.at_interface));
               check_field("is_moving", 64'(want.is_moving), 64'(rsp_item.is_moving));
               check_field("out_x", 64'(want.out_x), 64'(rsp_item.out_x));
               check_field("out_y", 64'(want.out_y), 64'(rsp_item.out_y));
               check_field("out_z", 64'(want.out_z), 64'(rsp_item.out_z));
               check_field("idle_count", 64'(want.idle_count), 64'(rsp_item.idle_count));
               check_field("stopped_total", 64'(want.stopped_total),
                           64'(rsp_item.stopped_total));
               check_field("box_min_x", 64'(want.box_min_x), 64'(rsp_item.box_min_x));
               check_field("box_min_y", 64'(want.box_min_y), 64'(rsp_item.box_min_y));
               check_field("box_min_z", 64'(want.box_min_z), 64'(rsp_item.box_min_z));
               check_field("box_max_x", 64'(want.box_max_x), 64'(rsp_item.box_max_x));
               check_field("box_max_packed_yz", 64'(want.box_max_packed_yz),
                           64'(rsp_item.box_max_packed_yz));
            end
         end
      end
      awaiting = due_results.size();
   end

endmodule

// ===== tb/sv/tb_mesh_node_position_commit_unit.sv =====
`timescale 1ns / 1ps
// Top of the mesh node position commit testbench: clock, reset, request, register and
// result stimulus, and the verdict. Depends on mnpc_pkg, mnpc_commit_checker and the block.
module tb_mesh_node_position_commit_unit;
   import mnpc_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int COORD_MIN = -8388608;
   localparam int COORD_MAX = 8388607;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    mismatches;
   int                    awaiting;
   int                    steady_left = 0;

   mesh_node_position_commit_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   mnpc_commit_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [23:0] rand_coord(input int bits);
      if (bits >= 24) return 24'($urandom);
      return 24'($urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1)));
   endfunction

   function automatic logic signed [23:0] nudge(input logic signed [23:0] c, input int reach);
      int d;
      d = $urandom_range(0, 2 * reach) - reach;
      return 24'(c + d);
   endfunction

   function automatic req_type mk(input logic [1:0] k, input int n,
                                  input int cx, cy, cz, px, py, pz);
      req_type r;
      r.kind = k;
      r.node_index = 12'(n);
      r.cur_x = 24'(cx);  r.cur_y = 24'(cy);  r.cur_z = 24'(cz);
      r.prop_x = 24'(px); r.prop_y = 24'(py); r.prop_z = 24'(pz);
      return r;
   endfunction

   function automatic cfg_type cfg_of(input logic [47:0] na, nb,
                                      input logic signed [23:0] oa, ob,
                                      input logic [49:0] thr, input logic [7:0] lim);
      cfg_type c;
      c.plane_a_normal = na;
      c.plane_b_normal = nb;
      c.plane_a_offset = oa;
      c.plane_b_offset = ob;
      c.move_threshold_squared = thr;
      c.inactive_limit = lim;
      return c;
   endfunction

   task automatic send_req(input req_type r);
      int gap;
      if (steady_left > 0) begin
         steady_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0) steady_left = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Valid stays high across the writes of one batch; it drops after the last.
   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      put_reg(CSR_PLANE_A_NORMAL, {2'd0, c.plane_a_normal});
      put_reg(CSR_PLANE_B_NORMAL, {2'd0, c.plane_b_normal});
      put_reg(CSR_PLANE_A_OFFSET, {26'd0, c.plane_a_offset});
      put_reg(CSR_PLANE_B_OFFSET, {26'd0, c.plane_b_offset});
      put_reg(CSR_MOVE_THRESH_SQ, c.move_threshold_squared);
      put_reg(CSR_INACTIVE_LIMIT, {42'd0, c.inactive_limit});
      csr_valid <= 1'b0;
   endtask

   // The first edge lets the checker record the last accepted transaction.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int pool, input int bits,
                            input int commit_pct);
      req_type r;
      int      sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < commit_pct) r.kind = KIND_COMMIT;
         else if (sel < commit_pct + (100 - commit_pct) / 3) r.kind = KIND_REINIT;
         else if (sel < commit_pct + 2 * (100 - commit_pct) / 3) r.kind = KIND_CLEAR_TOTAL;
         else r.kind = KIND_SPARE;
         r.node_index = (pool >= NODE_COUNT) ? 12'($urandom) : 12'($urandom_range(0, pool - 1));
         r.cur_x = rand_coord(bits);
         r.cur_y = rand_coord(bits);
         r.cur_z = rand_coord(bits);
         sel = $urandom_range(0, 9);
         if (sel < 5) begin
            r.prop_x = nudge(r.cur_x, 255);
            r.prop_y = nudge(r.cur_y, 255);
            r.prop_z = nudge(r.cur_z, 255);
         end else if (sel < 8) begin
            r.prop_x = nudge(r.cur_x, 2047);
            r.prop_y = nudge(r.cur_y, 2047);
            r.prop_z = nudge(r.cur_z, 2047);
         end else begin
            r.prop_x = rand_coord(bits);
            r.prop_y = rand_coord(bits);
            r.prop_z = rand_coord(bits);
         end
         send_req(r);
      end
   endtask

   // Result side: random stalls with calm stretches, plus one long hold-off that lets
   // the request side back up until the block refuses further transactions.
   initial begin : sink
      int  stall, calm, taken;
      bit  squeezed;
      stall = 0;
      calm = 0;
      taken = 0;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         if (!squeezed && taken >= 400) begin
            squeezed = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (calm > 0) begin
            calm--;
            rsp_ready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall = pick_gap();
            if ($urandom_range(0, 99) == 0) calm = $urandom_range(30, 120);
         end
      end
   end

   initial begin : stimulus
      @(posedge clock);
      while (reset) @(posedge clock);

      // Reset settings: planes at z = +1.0 and z = -1.0, threshold 1.0, limit 1.
      send_req(mk(KIND_COMMIT, 0, 0, 0, 0, 512, 0, 0));
      send_req(mk(KIND_COMMIT, 5, 0, 0, 0, 16, 16, 0));
      send_req(mk(KIND_COMMIT, 5, 0, 0, 0, 16, 16, 0));
      send_req(mk(KIND_COMMIT, 5, 0, 0, 0, 16, 16, 0));
      send_req(mk(KIND_COMMIT, 7, 0, 0, 0, 0, 0, 512));
      send_req(mk(KIND_COMMIT, 7, 0, 0, 0, 0, 0, -512));
      send_req(mk(KIND_COMMIT, 8, 0, 0, 256, 256, 0, 256));
      send_req(mk(KIND_COMMIT, 9, 0, 0, 0, 0, 0, 255));
      send_req(mk(KIND_COMMIT, 9, 0, 0, 0, 0, 0, 257));
      send_req(mk(KIND_COMMIT, 4095, COORD_MIN, COORD_MIN, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX));
      send_req(mk(KIND_COMMIT, 4094, COORD_MAX, COORD_MAX, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN));
      send_req(mk(KIND_COMMIT, 4093, 0, 0, COORD_MIN, 0, 0, COORD_MAX));
      send_req(mk(KIND_REINIT, 5, 100, 200, 300, 400, 500, 600));
      send_req(mk(KIND_COMMIT, 5, 0, 0, 0, 1, 0, 0));
      send_req(mk(KIND_CLEAR_TOTAL, 5, -7, 8, -9, 1000, 1000, 1000));
      send_req(mk(KIND_SPARE, 5, COORD_MAX, COORD_MIN, 3, -3, 77, COORD_MAX));
      send_req(mk(KIND_COMMIT, 5, 0, 0, 0, 256, 0, 0));
      send_req(mk(KIND_COMMIT, 10, 50, 60, 70, 50, 60, 70));
      send_req(mk(KIND_COMMIT, 10, 50, 60, 70, 50, 60, 70));
      send_req(mk(KIND_COMMIT, 10, 0, 0, 0, -1000, 2000, 100));
      send_req(mk(KIND_REINIT, 4095, COORD_MIN, COORD_MAX, COORD_MIN,
                  COORD_MAX, COORD_MIN, COORD_MAX));
      send_req(mk(KIND_CLEAR_TOTAL, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MIN, COORD_MIN, COORD_MIN));
      drain();

      // Axis planes at z = +/-64.0 and a 2.0 move threshold on a few busy nodes.
      program_regs(cfg_of(48'h0000_0000_4000, 48'h0000_0000_C000, 24'sd16384, 24'sd16384,
                          50'd262144, 8'd3));
      run_phase(250, 16, 16, 82);
      drain();

      // Everything random over the full range; the long result stall lands here.
      program_regs(cfg_of(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          24'($urandom), 24'($urandom),
                          50'({$urandom, $urandom}), 8'($urandom_range(0, 255))));
      run_phase(150, NODE_COUNT, 24, 82);
      drain();

      // Largest threshold and limit on one node: every move is short, the count
      // saturates and the node never stops.
      program_regs(cfg_of(48'h0, 48'hFFFF_FFFF_FFFF, 24'sh800000, 24'sh7FFFFF,
                          50'h3_FFFF_FFFF_FFFF, 8'd255));
      run_phase(300, 1, 20, 100);
      drain();

      // Zero threshold and limit: every move is long.
      program_regs(cfg_of(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 24'sd0, 24'sd0,
                          50'd0, 8'd0));
      run_phase(150, NODE_COUNT, 24, 82);
      drain();

      // Tilted plane and a y plane near the origin; the first short move stops a node.
      program_regs(cfg_of({16'h2D41, 16'h0000, 16'h2D41}, 48'h0000_4000_0000,
                          24'sd2560, -24'sd1280, 50'd40000, 8'd0));
      run_phase(250, 4, 12, 85);
      drain();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
